// ----- rtl/core/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, register indexes and helpers of the COBS stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_EN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_BYTE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LEN   = 3'd4;

   localparam logic [7:0] BYTE_MAX  = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   localparam logic [7:0] DELIM_RST   = 8'h00;
   localparam logic [5:0] DEPTH_RST   = 6'd32;
   localparam logic [7:0] RUN_BYTE_RST = 8'h00;
   localparam logic [3:0] RUN_LEN_RST = 4'd2;

   // most bytes sent for one item; later bytes of the item are dropped
   localparam int EMIT_MAX = 52;

   typedef struct packed {
      logic [7:0] delimiter_value;
      logic [5:0] block_depth;
      logic       run_mode_enable;
      logic [7:0] run_byte;
      logic [3:0] run_length;
   } cfg_type;

   typedef struct packed {
      logic       push;
      logic       close;
      logic [7:0] data;
   } emit_cmd_type;

   // code equal to a nonzero delimiter goes out as zero
   function automatic logic [7:0] code_adj(input logic [7:0] code, input logic [7:0] delim);
      logic [7:0] res;
      res = code;
      if ((delim != BYTE_ZERO) && (code == delim)) begin
         res = BYTE_ZERO;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cse_buf_ram.sv -----
// ----------------------------------------------------------------------------
// cse_buf_ram
// Block buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_buf_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cse_emit.sv -----
// ----------------------------------------------------------------------------
// cse_emit
// Result stage: a one-byte hold register ahead of the output register, so
// the last byte of an item can be flagged when the item closes.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cse_pkg::emit_cmd_type cmd,
   output logic                       rdy,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run
);
   import cse_pkg::*;

   logic       hold_vld_ff, hold_vld_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rdy      = !hold_vld_ff || out_free;

   always_comb begin
      hold_vld_in  = hold_vld_ff;
      hold_byte_in = hold_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if ((cmd.push || cmd.close) && rdy) begin
         if (hold_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = hold_byte_ff;
            rsp_last_in  = cmd.close;
         end
         if (cmd.push) begin
            hold_vld_in  = 1'b1;
            hold_byte_in = cmd.data;
         end else begin
            hold_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_byte_ff <= hold_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cse_ctrl.sv -----
// ----------------------------------------------------------------------------
// cse_ctrl
// Encoder sequencer: fill position, pending run count, buffer writes and
// block flushes read back from the buffer RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_ctrl #(
   parameter int BUF_DEPTH = 32,
   parameter int MAX_RUN   = 15,
   parameter int AW        = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cse_pkg::cfg_type      cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [7:0]            req_data_byte,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [7:0]                 wr_data,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   input  wire logic [7:0]            rd_data,
   output cse_pkg::emit_cmd_type      emit_cmd,
   input  wire logic                  emit_rdy
);
   import cse_pkg::*;

   localparam int POS_W  = $clog2(BUF_DEPTH + 1);
   localparam int PEND_W = $clog2(MAX_RUN + 1);
   localparam int CW     = 10;
   localparam int ECW    = $clog2(EMIT_MAX + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENC_CHK,
      S_ENC_PUT,
      S_ENC_END,
      S_FIN_CHK,
      S_FIN_FL,
      S_FIN_DLM,
      S_FL_CODE,
      S_FL_DATA,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   state_type         ret_ff, ret_in;
   logic [POS_W-1:0]  fill_ff, fill_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              op_ff, op_in;
   logic [7:0]        byte_ff, byte_in;
   logic              replay_ff, replay_in;
   logic [7:0]        code_ff, code_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [ECW-1:0]    ecnt_ff, ecnt_in;

   logic [CW-1:0]     bd_w, d_w, fill_w, rl_w, rle_w, sum_w;
   logic [PEND_W:0]   pend_inc;
   logic              full, run_hit;
   logic [7:0]        cur_byte;
   logic [POS_W-1:0]  idx_nx;

   always_comb begin
      bd_w = CW'(cfg.block_depth);
      if (bd_w < CW'(2)) begin
         d_w = CW'(2);
      end else if (bd_w > CW'(BUF_DEPTH)) begin
         d_w = CW'(BUF_DEPTH);
      end else begin
         d_w = bd_w;
      end
      rl_w = CW'(cfg.run_length);
      if (rl_w < CW'(1)) begin
         rle_w = CW'(1);
      end else if (rl_w > CW'(MAX_RUN)) begin
         rle_w = CW'(MAX_RUN);
      end else begin
         rle_w = rl_w;
      end
   end

   assign fill_w   = CW'(fill_ff);
   assign sum_w    = fill_w + d_w;
   assign full     = fill_w >= d_w;
   assign cur_byte = replay_ff ? cfg.run_byte : byte_ff;
   assign pend_inc = {1'b0, pend_ff} + 1'b1;
   assign idx_nx   = idx_ff + 1'b1;
   assign run_hit  = !req_opcode && cfg.run_mode_enable &&
                     (req_data_byte == cfg.run_byte) && (sum_w <= CW'(BYTE_MAX));
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      pend_in   = pend_ff;
      op_in     = op_ff;
      byte_in   = byte_ff;
      replay_in = replay_ff;
      code_in   = code_ff;
      idx_in    = idx_ff;
      ecnt_in   = ecnt_ff;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[AW-1:0];
      wr_data   = cur_byte;
      rd_en     = 1'b0;
      rd_addr   = idx_nx[AW-1:0];
      emit_cmd  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_opcode;
               byte_in = req_data_byte;
               ecnt_in = '0;
               if (run_hit) begin
                  if (CW'(pend_inc) >= rle_w) begin
                     pend_in  = '0;
                     code_in  = code_adj(sum_w[7:0], cfg.delimiter_value);
                     ret_in   = S_DONE;
                     state_in = S_FL_CODE;
                  end else begin
                     pend_in  = pend_inc[PEND_W-1:0];
                     state_in = S_DONE;
                  end
               end else begin
                  replay_in = (pend_ff != '0);
                  if ((pend_ff != '0) || !req_opcode) begin
                     state_in = S_ENC_CHK;
                  end else begin
                     state_in = S_FIN_CHK;
                  end
               end
            end
         end
         S_ENC_CHK: begin
            if (full) begin
               code_in  = code_adj(fill_w[7:0], cfg.delimiter_value);
               ret_in   = S_ENC_PUT;
               state_in = S_FL_CODE;
            end else begin
               state_in = S_ENC_PUT;
            end
         end
         S_ENC_PUT: begin
            if (cur_byte != cfg.delimiter_value) begin
               if (fill_w < CW'(BUF_DEPTH)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               state_in = S_ENC_END;
            end else begin
               code_in  = code_adj(fill_w[7:0], cfg.delimiter_value);
               ret_in   = S_ENC_END;
               state_in = S_FL_CODE;
            end
         end
         S_ENC_END: begin
            if (replay_ff) begin
               pend_in = pend_ff - 1'b1;
               if (pend_ff == PEND_W'(1)) begin
                  replay_in = 1'b0;
                  state_in  = op_ff ? S_FIN_CHK : S_ENC_CHK;
               end else begin
                  state_in = S_ENC_CHK;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIN_CHK: begin
            if (full) begin
               code_in  = code_adj(fill_w[7:0], cfg.delimiter_value);
               ret_in   = S_FIN_FL;
               state_in = S_FL_CODE;
            end else begin
               state_in = S_FIN_FL;
            end
         end
         S_FIN_FL: begin
            code_in  = code_adj(fill_w[7:0], cfg.delimiter_value);
            ret_in   = S_FIN_DLM;
            state_in = S_FL_CODE;
         end
         S_FIN_DLM: begin
            if (emit_rdy) begin
               emit_cmd.push = 1'b1;
               emit_cmd.data = cfg.delimiter_value;
               state_in      = S_DONE;
            end
         end
         S_FL_CODE: begin
            if (emit_rdy) begin
               emit_cmd.push = 1'b1;
               emit_cmd.data = code_ff;
               if (fill_ff == POS_W'(1)) begin
                  state_in = ret_ff;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(1);
                  idx_in   = POS_W'(1);
                  state_in = S_FL_DATA;
               end
            end
         end
         S_FL_DATA: begin
            if (emit_rdy) begin
               emit_cmd.push = 1'b1;
               emit_cmd.data = rd_data;
               if (idx_nx < fill_ff) begin
                  rd_en  = 1'b1;
                  idx_in = idx_nx;
               end else begin
                  fill_in  = POS_W'(1);
                  state_in = ret_ff;
               end
            end
         end
         S_DONE: begin
            if (emit_rdy) begin
               emit_cmd.close = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // bytes past the per-item cap are dropped
      if (emit_cmd.push) begin
         if (ecnt_ff < ECW'(EMIT_MAX)) begin
            ecnt_in = ecnt_ff + 1'b1;
         end else begin
            emit_cmd.push = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_DONE;
         fill_ff   <= POS_W'(1);
         pend_ff   <= '0;
         replay_ff <= 1'b0;
         ecnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
         replay_ff <= replay_in;
         ecnt_ff   <= ecnt_in;
      end
      op_ff   <= op_in;
      byte_ff <= byte_in;
      code_ff <= code_in;
      idx_ff  <= idx_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/cobs_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// cobs_stream_encoder
// A buffered byte and each replayed run byte pass the check, put and end
// states, with req_ready low. A flush sends its code, then streams one buffer
// byte per cycle from the buffer RAM read port while the result stage is
// ready; the final byte of an item leaves in the cycle after the item closes.
// One item at a time. Reset clears control state and loads register defaults;
// buffer RAM is not cleared (slots are written before they are read).
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_stream_encoder #(
   parameter int BUF_DEPTH = 32,
   parameter int MAX_RUN   = 15
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [cse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cse_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_opcode,
   input  wire logic [7:0]                     req_data_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last_of_run
);
   import cse_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   cfg_type      cfg_ff, cfg_in;
   logic         wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]   wr_data, rd_data;
   emit_cmd_type emit_cmd;
   logic         emit_rdy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELIMITER: cfg_in.delimiter_value = csr_wdata[7:0];
            CSR_DEPTH:     cfg_in.block_depth     = csr_wdata[5:0];
            CSR_RUN_EN:    cfg_in.run_mode_enable = csr_wdata[0];
            CSR_RUN_BYTE:  cfg_in.run_byte        = csr_wdata[7:0];
            CSR_RUN_LEN:   cfg_in.run_length      = csr_wdata[3:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_value <= DELIM_RST;
         cfg_ff.block_depth     <= DEPTH_RST;
         cfg_ff.run_mode_enable <= 1'b0;
         cfg_ff.run_byte        <= RUN_BYTE_RST;
         cfg_ff.run_length      <= RUN_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cse_ctrl #(
      .BUF_DEPTH (BUF_DEPTH),
      .MAX_RUN   (MAX_RUN),
      .AW        (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .emit_cmd      (emit_cmd),
      .emit_rdy      (emit_rdy)
   );

   cse_buf_ram #(
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cse_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .cmd             (emit_cmd),
      .rdy             (emit_rdy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ----- rtl/core/cse_checker.sv -----
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks of the COBS stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_of_run
);

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("outputs not idle after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an input transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_out_byte) && $stable(rsp_last_of_run)))
      else $error("rsp payload changed while stalled");

endmodule

bind cobs_stream_encoder cse_checker u_cse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire

// ----- sim/cse_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_tb_pkg
// Item codes shared by the COBS stream encoder stimulus and checker.
// ----------------------------------------------------------------------------
package cse_tb_pkg;

   typedef enum logic {
      OP_BYTE   = 1'b0,
      OP_FINISH = 1'b1
   } opcode_type;

endpackage

// ----- sim/cobs_stream_encoder_chk.sv -----
// ----------------------------------------------------------------------------
// cobs_stream_encoder_chk
// Watches the register, request and response channels of the COBS stream
// encoder, keeps its own copy of the block buffer and run state, predicts the
// encoded bytes of every accepted item and compares each response transfer
// against the oldest prediction.
// ----------------------------------------------------------------------------
module cobs_stream_encoder_chk #(
   parameter int BUF_DEPTH = 32,
   parameter int MAX_RUN   = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [cse_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cse_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [7:0]                    rsp_out_byte,
   input  wire logic                          rsp_last_of_run,
   output int                                 fail_count,
   output int                                 outstanding
);
   import cse_pkg::*;
   import cse_tb_pkg::*;

   localparam int MAX_BYTES_PER_ITEM = 52;
   localparam int REPORT_LIMIT       = 10;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } coded_byte_type;

   cfg_type        cfg;
   logic [7:0]     blk [BUF_DEPTH];
   logic [5:0]     fill_pos;
   logic [3:0]     run_pending;
   coded_byte_type coded_q [$];
   logic [7:0]     item_bytes [$];

   function automatic logic [5:0] depth_now();
      if (cfg.block_depth < 6'd2) return 6'd2;
      if (cfg.block_depth > 6'(BUF_DEPTH)) return 6'(BUF_DEPTH);
      return cfg.block_depth;
   endfunction

   function automatic logic [3:0] run_len_now();
      if (cfg.run_length == 4'd0) return 4'd1;
      if (int'(cfg.run_length) > MAX_RUN) return 4'(MAX_RUN);
      return cfg.run_length;
   endfunction

   function automatic void send_out(input logic [7:0] b);
      if (item_bytes.size() < MAX_BYTES_PER_ITEM) item_bytes.push_back(b);
   endfunction

   function automatic void flush_block(input logic [7:0] code);
      logic [7:0] c;
      int         n;
      c = code;
      if ((cfg.delimiter_value != BYTE_ZERO) && (c == cfg.delimiter_value)) c = BYTE_ZERO;
      blk[0] = c;
      n = (int'(fill_pos) > BUF_DEPTH) ? BUF_DEPTH : int'(fill_pos);
      for (int i = 0; i < n; i++) send_out(blk[i]);
      fill_pos = 6'd1;
   endfunction

   function automatic void flush_if_full();
      if (fill_pos >= depth_now()) flush_block(8'(fill_pos));
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      flush_if_full();
      if (b != cfg.delimiter_value) begin
         if (int'(fill_pos) < BUF_DEPTH) begin
            blk[fill_pos] = b;
            fill_pos++;
         end
      end else begin
         flush_block(8'(fill_pos));
      end
   endfunction

   function automatic void replay_run();
      while (run_pending != 4'd0) begin
         put_byte(cfg.run_byte);
         run_pending--;
      end
   endfunction

   function automatic void encode_item(input opcode_type op, input logic [7:0] b);
      logic [5:0]     d;
      coded_byte_type cb;
      d = depth_now();
      item_bytes.delete();
      if (op == OP_FINISH) begin
         replay_run();
         flush_if_full();
         flush_block(8'(fill_pos));
         send_out(cfg.delimiter_value);
      end else if (cfg.run_mode_enable && (b == cfg.run_byte) &&
                   (int'(fill_pos) <= 255 - int'(d))) begin
         run_pending++;
         if (run_pending >= run_len_now()) begin
            flush_block(8'(fill_pos) + 8'(d));
            run_pending = 4'd0;
         end
      end else begin
         replay_run();
         put_byte(b);
      end
      foreach (item_bytes[i]) begin
         cb.value = item_bytes[i];
         cb.last  = (i == item_bytes.size() - 1);
         coded_q.push_back(cb);
      end
   endfunction

   always @(posedge clock) begin : watch
      coded_byte_type want;
      if (reset) begin
         cfg.delimiter_value = DELIM_RST;
         cfg.block_depth     = DEPTH_RST;
         cfg.run_mode_enable = 1'b0;
         cfg.run_byte        = RUN_BYTE_RST;
         cfg.run_length      = RUN_LEN_RST;
         foreach (blk[i]) blk[i] = BYTE_ZERO;
         fill_pos    = 6'd1;
         run_pending = 4'd0;
         coded_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DELIMITER: cfg.delimiter_value = csr_wdata[7:0];
               CSR_DEPTH:     cfg.block_depth     = csr_wdata[5:0];
               CSR_RUN_EN:    cfg.run_mode_enable = csr_wdata[0];
               CSR_RUN_BYTE:  cfg.run_byte        = csr_wdata[7:0];
               CSR_RUN_LEN:   cfg.run_length      = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) encode_item(opcode_type'(req_opcode), req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (coded_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: unexpected transfer, byte %02h last %0b",
                           $realtime, rsp_out_byte, rsp_last_of_run);
               fail_count++;
            end else begin
               want = coded_q.pop_front();
               if ((want.value !== rsp_out_byte) || (want.last !== rsp_last_of_run)) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"%0t: mismatch, expected byte %02h last %0b, ",
                               "got byte %02h last %0b"},
                              $realtime, want.value, want.last, rsp_out_byte, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
      end
      outstanding = coded_q.size();
   end

endmodule

// ----- sim/cobs_stream_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// cobs_stream_encoder_tb
// Drives the COBS stream encoder with directed corner cases and randomized
// framed traffic over several register settings, with random idling on both
// channels, a long response hold-off and drain pauses. The checker beside the
// block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module cobs_stream_encoder_tb;
   import cse_pkg::*;
   import cse_tb_pkg::*;

   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_opcode;
   logic [7:0]           req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last_of_run;

   int      fail_count;
   int      outstanding;
   int      quiet;
   int      hold_asks;
   int      holds_done;
   bit      no_idle;
   cfg_type cfg;

   cobs_stream_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   cobs_stream_encoder_chk chk (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin : rx_side
      int span;
      rsp_ready  = 1'b0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_asks) begin
            holds_done++;
            rsp_ready <= 1'b0;
            span = HOLD_CYCLES;
         end else if (no_idle || ($urandom_range(0, 3) != 0)) begin
            rsp_ready <= 1'b1;
            span = $urandom_range(1, 6);
         end else begin
            rsp_ready <= 1'b0;
            span = 1 + idle_len();
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   task automatic send_item(input opcode_type op, input logic [7:0] b);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_cfg();
      settle();
      write_reg(CSR_DELIMITER, cfg.delimiter_value);
      write_reg(CSR_DEPTH, {2'b00, cfg.block_depth});
      write_reg(CSR_RUN_EN, {7'd0, cfg.run_mode_enable});
      write_reg(CSR_RUN_BYTE, cfg.run_byte);
      write_reg(CSR_RUN_LEN, {4'd0, cfg.run_length});
   endtask

   task automatic pick_cfg(input int phase);
      case ($urandom_range(0, 3))
         0:       cfg.delimiter_value = BYTE_ZERO;
         1:       cfg.delimiter_value = BYTE_MAX;
         default: cfg.delimiter_value = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       cfg.block_depth = 6'd0;
         1:       cfg.block_depth = 6'd1;
         2:       cfg.block_depth = 6'd63;
         3:       cfg.block_depth = 6'd33;
         4:       cfg.block_depth = 6'($urandom_range(2, 32));
         default: cfg.block_depth = 6'($urandom_range(2, 6));
      endcase
      cfg.run_mode_enable = ($urandom_range(0, 3) != 0);
      cfg.run_byte = ($urandom_range(0, 4) == 0) ? cfg.delimiter_value : 8'($urandom);
      cfg.run_length = 4'($urandom_range(0, 15));
      if (phase == 0) cfg = '{BYTE_MAX, 6'd2, 1'b1, BYTE_MAX, 4'd15};
      if (phase == 1) cfg = '{BYTE_ZERO, 6'd32, 1'b1, BYTE_ZERO, 4'd1};
      if (phase == 4) cfg.block_depth = 6'd3;
   endtask

   task automatic random_traffic(input int count);
      int sent;
      int k;
      int r;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            send_item(OP_FINISH, 8'($urandom));
            sent++;
         end else if (r < 25) begin
            send_item(OP_BYTE, cfg.delimiter_value);
            sent++;
         end else if ((r < 55) && cfg.run_mode_enable) begin
            k = (cfg.run_length == 4'd0) ? 1 : int'(cfg.run_length);
            if ($urandom_range(0, 3) == 0) k = $urandom_range(1, k);
            repeat (k) send_item(OP_BYTE, cfg.run_byte);
            sent += k;
         end else begin
            send_item(OP_BYTE, 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin : stim
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_BYTE;
      req_data_byte = BYTE_ZERO;
      csr_valid     = 1'b0;
      csr_index     = CSR_DELIMITER;
      csr_wdata     = BYTE_ZERO;
      hold_asks     = 0;
      no_idle       = 1'b0;
      cfg = '{DELIM_RST, DEPTH_RST, 1'b0, RUN_BYTE_RST, RUN_LEN_RST};
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset settings: delimiter on empty block, byte extremes, empty frame
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'h01);
      send_item(OP_BYTE, 8'h80);
      send_item(OP_FINISH, 8'h00);
      send_item(OP_FINISH, 8'hFF);

      // code equal to nonzero delimiter, depth clamp high, run length lowered mid-run
      cfg = '{8'h03, 6'd63, 1'b1, 8'hAA, 4'd3};
      apply_cfg();
      send_item(OP_BYTE, 8'h11);
      send_item(OP_BYTE, 8'h22);
      send_item(OP_BYTE, 8'h03);
      send_item(OP_BYTE, 8'hAA);
      send_item(OP_BYTE, 8'hAA);
      cfg.run_length = 4'd1;
      apply_cfg();
      send_item(OP_BYTE, 8'hAA);

      // run byte changed mid-run, then pending run with run mode off
      cfg.run_length = 4'd2;
      apply_cfg();
      send_item(OP_BYTE, 8'hAA);
      cfg.run_byte = 8'hBB;
      apply_cfg();
      send_item(OP_BYTE, 8'h44);
      send_item(OP_BYTE, 8'hBB);
      cfg.run_mode_enable = 1'b0;
      apply_cfg();
      send_item(OP_FINISH, 8'h5A);

      // depth clamp low, zero run length
      cfg = '{BYTE_MAX, 6'd0, 1'b1, BYTE_ZERO, 4'd0};
      apply_cfg();
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'h55);
      send_item(OP_BYTE, 8'h66);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_FINISH, 8'h00);

      // fill above a lowered depth
      cfg = '{BYTE_ZERO, 6'd32, 1'b0, BYTE_ZERO, 4'd2};
      apply_cfg();
      send_item(OP_BYTE, 8'h12);
      send_item(OP_BYTE, 8'h34);
      send_item(OP_BYTE, 8'h56);
      cfg.block_depth = 6'd3;
      apply_cfg();
      send_item(OP_BYTE, 8'h78);
      send_item(OP_FINISH, 8'h00);

      for (int phase = 0; phase < 6; phase++) begin
         pick_cfg(phase);
         apply_cfg();
         no_idle = (phase == 3);
         if (phase == 4) hold_asks++;
         random_traffic((phase == 4) ? 24 : 12);
         no_idle = 1'b0;
      end

      settle();
      if ((fail_count == 0) && (outstanding == 0)) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
